/* hdl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Implication whose consequence is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* hdl/ucd_pkg.sv */
// Shared constants, types and state encoding for the decimal ASCII converter.
package ucd_pkg;

   // Width of the binary input value.
   localparam int unsigned VALUE_BITS = 32;
   // Decimal digits needed for the largest value: floor(bits * log10(2)) + 1.
   localparam int unsigned DIGITS     = (VALUE_BITS * 1233) / 4096 + 1;
   localparam int unsigned DIGIT_W    = 4;
   localparam int unsigned CHAR_W     = 6;
   localparam int unsigned BIT_CNT_W  = $clog2(VALUE_BITS + 1);
   localparam int unsigned DIG_CNT_W  = $clog2(DIGITS + 1);

   localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
   localparam logic [DIGIT_W-1:0] BCD_FIVE   = 4'd5;
   localparam logic [DIGIT_W-1:0] BCD_THREE  = 4'd3;
   localparam logic [DIGIT_W-1:0] BCD_NINE   = 4'd9;

   typedef logic [DIGIT_W-1:0] bcd_type;

   // Per-cycle command broadcast to every digit cell.
   typedef struct packed {
      logic clear;   // start a new number
      logic conv;    // one double-dabble step
      logic move;    // digits move one cell toward the top
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_EMIT
   } state_type;

endpackage

/* hdl/ucd_if.sv */
// Request and response channel interfaces of the decimal ASCII converter.
interface ucd_req_if;
   logic                            valid;
   logic                            ready;
   logic [ucd_pkg::VALUE_BITS-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface ucd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ucd_pkg::CHAR_W-1:0]  digit_char;
   logic                        last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

/* hdl/u32_to_decimal_ascii.sv */
// Top level: converts one unsigned binary value per request to decimal ASCII characters.
//
// Each request carries a 32-bit unsigned value; the block returns its decimal
// text one ASCII character per response, most significant digit first, with
// leading zeros dropped ('0' alone for zero) and last_digit set on the final
// character. A value runs through 32 double-dabble steps in a row of ten BCD
// digit cells, one input bit per cycle, then the leading zeros move out of
// the top cell, then the characters are emitted, each as soon as the output
// register is free.
// A new request is taken as soon as the last character is in the output
// register, even if that character has not yet been taken.
`include "assert_macros.svh"

module u32_to_decimal_ascii (
   input  logic           clock,
   input  logic           reset,
   ucd_req_if.sink        req_if,
   ucd_rsp_if.source      rsp_if
);

   ucd_pkg::state_type                 state_ff, state_in;
   logic [ucd_pkg::VALUE_BITS-1:0]     bin_ff, bin_in;
   logic [ucd_pkg::BIT_CNT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [ucd_pkg::DIG_CNT_W-1:0]      dig_cnt_ff, dig_cnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ucd_pkg::CHAR_W-1:0]         rsp_char_ff, rsp_char_in;
   logic                               rsp_last_ff, rsp_last_in;

   ucd_pkg::cell_ctl_type              ctl;
   logic                               carry [ucd_pkg::DIGITS-1:0];
   ucd_pkg::bcd_type                   dig   [ucd_pkg::DIGITS-1:0];
   logic                               top_carry;
   ucd_pkg::bcd_type                   top_digit;
   logic                               slot_free;

   // Digit cell chain: carries move up during conversion, digits move up
   // during output so the top cell always holds the next character.
   assign carry[0] = bin_ff[ucd_pkg::VALUE_BITS-1];

   for (genvar i = 0; i < ucd_pkg::DIGITS; i++) begin : g_cell
      ucd_pkg::bcd_type prev;
      logic             cout;

      if (i == 0) begin : g_first
         assign prev = '0;
      end else begin : g_rest
         assign prev = dig[i-1];
      end

      if (i == ucd_pkg::DIGITS - 1) begin : g_top
         assign top_carry = cout;
      end else begin : g_mid
         assign carry[i+1] = cout;
      end

      ucd_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .carry_in   (carry[i]),
         .prev_digit (prev),
         .carry_out  (cout),
         .digit_out  (dig[i])
      );
   end

   assign top_digit = dig[ucd_pkg::DIGITS-1];
   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   // Sequencer: load, convert, skip leading zeros, emit characters.
   always_comb begin
      state_in      = state_ff;
      bin_in        = bin_ff;
      bit_cnt_in    = bit_cnt_ff;
      dig_cnt_in    = dig_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      ctl           = '0;
      req_if.ready  = 1'b0;

      case (state_ff)
         ucd_pkg::ST_IDLE: begin
            // no request is taken while reset is held
            req_if.ready = !reset;
            if (req_if.valid && !reset) begin
               bin_in     = req_if.value;
               bit_cnt_in = ucd_pkg::BIT_CNT_W'(ucd_pkg::VALUE_BITS);
               ctl.clear  = 1'b1;
               state_in   = ucd_pkg::ST_CONV;
            end
         end
         ucd_pkg::ST_CONV: begin
            ctl.conv   = 1'b1;
            bin_in     = bin_ff << 1;
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == ucd_pkg::BIT_CNT_W'(1)) begin
               dig_cnt_in = ucd_pkg::DIG_CNT_W'(ucd_pkg::DIGITS);
               state_in   = ucd_pkg::ST_SKIP;
            end
         end
         ucd_pkg::ST_SKIP: begin
            // drop leading zeros, keeping at least one digit
            if (top_digit == '0 && dig_cnt_ff > ucd_pkg::DIG_CNT_W'(1)) begin
               ctl.move   = 1'b1;
               dig_cnt_in = dig_cnt_ff - 1'b1;
            end else begin
               state_in = ucd_pkg::ST_EMIT;
            end
         end
         ucd_pkg::ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ucd_pkg::ASCII_ZERO + {2'b00, top_digit};
               rsp_last_in  = (dig_cnt_ff == ucd_pkg::DIG_CNT_W'(1));
               ctl.move     = 1'b1;
               dig_cnt_in   = dig_cnt_ff - 1'b1;
               if (dig_cnt_ff == ucd_pkg::DIG_CNT_W'(1)) begin
                  state_in = ucd_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ucd_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ucd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.digit_char = rsp_char_ff;
   assign rsp_if.last_digit = rsp_last_ff;

   // Checks
   `ASSERT_IMPL(a_no_overflow, clock, reset, state_ff == ucd_pkg::ST_CONV, !top_carry)
   `ASSERT_IMPL(a_top_is_bcd, clock, reset,
      state_ff == ucd_pkg::ST_SKIP || state_ff == ucd_pkg::ST_EMIT,
      top_digit <= ucd_pkg::BCD_NINE && dig_cnt_ff != '0)
   `ASSERT_IMPL(a_char_range, clock, reset, rsp_valid_ff,
      rsp_char_ff >= ucd_pkg::ASCII_ZERO &&
      rsp_char_ff <= ucd_pkg::ASCII_ZERO + ucd_pkg::CHAR_W'(ucd_pkg::BCD_NINE))
   `ASSERT_NEXT(a_last_ends, clock, reset,
      state_ff == ucd_pkg::ST_EMIT && slot_free && dig_cnt_ff == ucd_pkg::DIG_CNT_W'(1),
      state_ff == ucd_pkg::ST_IDLE && rsp_valid_ff && rsp_last_ff)

endmodule

/* hdl/ucd_cell.sv */
// One BCD digit cell of the double-dabble chain.
module ucd_cell (
   input  logic                  clock,
   input  ucd_pkg::cell_ctl_type ctl,
   input  logic                  carry_in,
   input  ucd_pkg::bcd_type      prev_digit,
   output logic                  carry_out,
   output ucd_pkg::bcd_type      digit_out
);

   ucd_pkg::bcd_type dig_ff;
   ucd_pkg::bcd_type dig_in;
   ucd_pkg::bcd_type adj;

   // Add three when the digit would pass nine after doubling.
   assign adj = (dig_ff >= ucd_pkg::BCD_FIVE) ? dig_ff + ucd_pkg::BCD_THREE : dig_ff;

   always_comb begin
      dig_in = dig_ff;
      if (ctl.clear) begin
         dig_in = '0;
      end else if (ctl.conv) begin
         dig_in = {adj[ucd_pkg::DIGIT_W-2:0], carry_in};
      end else if (ctl.move) begin
         dig_in = prev_digit;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff <= dig_in;
   end

   assign carry_out = adj[ucd_pkg::DIGIT_W-1];
   assign digit_out = dig_ff;

endmodule

/* verif/tb.sv */
// Testbench for the decimal ASCII converter: directed and random requests, checked per character.
`timescale 1ns / 1ps

module tb;

   localparam int unsigned DEC_BASE       = 10;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned DRAIN_CYCLES   = 60;
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned REPORT_LIMIT   = 10;

   typedef struct {
      logic [ucd_pkg::CHAR_W-1:0] ascii;
      logic                       is_last;
   } digit_char_type;

   logic clock;
   logic reset;

   ucd_req_if req_ch ();
   ucd_rsp_if rsp_ch ();

   u32_to_decimal_ascii DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // characters still owed by the block, oldest first
   digit_char_type pending_chars[$];

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   logic        hold_rsp       = 1'b0;
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles   = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Decimal text of one value, most significant digit first.
   function automatic void queue_decimal_text(input logic [ucd_pkg::VALUE_BITS-1:0] value);
      logic [ucd_pkg::VALUE_BITS-1:0] rest;
      ucd_pkg::bcd_type               digits[$];
      digit_char_type                 item;
      rest = value;
      do begin
         digits.push_front(ucd_pkg::bcd_type'(rest % DEC_BASE));
         rest = rest / DEC_BASE;
      end while (rest != 0);
      foreach (digits[k]) begin
         item.ascii   = ucd_pkg::ASCII_ZERO + ucd_pkg::CHAR_W'(digits[k]);
         item.is_last = (k == digits.size() - 1);
         pending_chars.push_back(item);
      end
   endfunction

   // Half fully random, half spread evenly over the digit counts 1..10.
   function automatic logic [ucd_pkg::VALUE_BITS-1:0] pick_value();
      int unsigned     ndig;
      longint unsigned lo;
      longint unsigned hi;
      if ($urandom_range(1) == 0)
         return $urandom;
      ndig = $urandom_range(10, 1);
      lo   = 1;
      repeat (ndig - 1) lo = lo * DEC_BASE;
      hi = lo * DEC_BASE - 1;
      if (ndig == 1)
         lo = 0;
      if (hi > 64'hFFFF_FFFF)
         hi = 64'hFFFF_FFFF;
      return ucd_pkg::VALUE_BITS'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
   endfunction

   // One request: optional idle gap, then hold valid until accepted.
   task automatic send_value(input logic [ucd_pkg::VALUE_BITS-1:0] value);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= value;
      do
         @(posedge clock);
      while (!req_ch.ready);
      queue_decimal_text(value);
   endtask

   // Response side: random stalls, or a long hold when asked.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Compare each accepted character with the oldest one owed.
   always @(posedge clock) begin
      digit_char_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: unexpected character %0d last %0b", $time,
                        rsp_ch.digit_char, rsp_ch.last_digit);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_ch.digit_char !== want.ascii || rsp_ch.last_digit !== want.is_last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: character exp %0d last %0b, got %0d last %0b", $time,
                           want.ascii, want.is_last, rsp_ch.digit_char, rsp_ch.last_digit);
            end
         end
      end
   end

   // Watchdog: too long with no request or character moving.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Extremes, digit-count boundaries and zero, with no idling.
   task automatic test_directed();
      logic [ucd_pkg::VALUE_BITS-1:0] values[$];
      values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd12345,
                 32'd99999, 32'd100000, 32'd9999999, 32'd10000000, 32'd123456789,
                 32'd999999999, 32'd1000000000, 32'd1234567890, 32'd2147483647,
                 32'd2147483648, 32'd4000000000, 32'd4294967294, 32'd4294967295,
                 32'hAAAA_AAAA, 32'h5555_5555};
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      foreach (values[i])
         send_value(values[i]);
   endtask

   task automatic test_random_flow(input int unsigned count, input int unsigned idle_pct,
                                   input int unsigned stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count)
         send_value(pick_value());
   endtask

   // Response side held off while requests keep coming, so the block backs up.
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_rsp <= 1'b1;
      repeat (6)
         send_value(pick_value());
   endtask

   initial begin
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.value <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_flow(90, 0, 0);
      test_random_flow(80, 67, 0);
      test_random_flow(80, 0, 67);
      test_backpressure();
      test_random_flow(80, 36, 36);
      test_random_flow(20, 0, 0);

      req_ch.valid <= 1'b0;
      while (pending_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_chars.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
